[hw/rtl/sidta_pkg.sv]
// Shared constants and types for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package sidta_pkg;

    localparam int DataWidth  = 32;
    localparam int NumDigits  = 10;
    localparam int BcdWidth   = 4 * NumDigits;
    localparam int StepWidth  = $clog2(DataWidth);
    localparam int IndexWidth = $clog2(NumDigits);

    localparam logic [7:0] CharZero  = 8'd48;
    localparam logic [7:0] CharMinus = 8'd45;

    // Converted magnitude handed from the BCD unit to the character emitter.
    typedef struct packed {
        logic                valid;
        logic                neg;
        logic [BcdWidth-1:0] bcd;
    } sidta_conv_t;

endpackage

[hw/rtl/sidta_dabble.sv]
// Iterative binary-to-BCD unit: one shift and add-3 step per cycle.
`timescale 1ns / 1ps

module sidta_dabble (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic                             neg,
    input  logic [sidta_pkg::DataWidth-1:0]  mag,
    output logic                             busy,
    output sidta_pkg::sidta_conv_t           conv
);

    logic                            active_reg;
    logic                            done_reg;
    logic [sidta_pkg::StepWidth-1:0] step_reg;
    logic [sidta_pkg::DataWidth-1:0] mag_reg;
    logic [sidta_pkg::BcdWidth-1:0]  bcd_reg;
    logic                            neg_reg;

    logic [sidta_pkg::BcdWidth-1:0]  bcd_adj;
    logic [sidta_pkg::BcdWidth-1:0]  bcd_next;

    // Add 3 to every digit of 5 or more before the shift.
    always_comb begin
        for (int i = 0; i < sidta_pkg::NumDigits; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
        bcd_next = {bcd_adj[sidta_pkg::BcdWidth-2:0], mag_reg[sidta_pkg::DataWidth-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
                step_reg   <= '0;
            end else if (active_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == sidta_pkg::StepWidth'(sidta_pkg::DataWidth - 1)) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= mag;
            bcd_reg <= '0;
            neg_reg <= neg;
        end else if (active_reg) begin
            mag_reg <= {mag_reg[sidta_pkg::DataWidth-2:0], 1'b0};
            bcd_reg <= bcd_next;
        end
    end

    assign busy       = active_reg | done_reg;
    assign conv.valid = done_reg;
    assign conv.neg   = neg_reg;
    assign conv.bcd   = bcd_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> !done_reg)
        else $error("BCD unit done while still stepping");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("BCD done held longer than one cycle");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy)
        else $error("BCD unit started while busy");

endmodule

[hw/rtl/sidta_emit.sv]
// Character emitter: sign, then digits from the leading nonzero one, into an output register.
`timescale 1ns / 1ps

module sidta_emit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sidta_pkg::sidta_conv_t conv,
    output logic                   busy,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_out_char,
    output logic                   m_last
);

    logic                                                 active_reg;
    logic                                                 neg_reg;
    logic [sidta_pkg::IndexWidth-1:0]                     idx_reg;
    logic [sidta_pkg::NumDigits-1:0][3:0]                 digit_reg;
    logic                                                 m_valid_reg;
    logic [7:0]                                           m_out_char_reg;
    logic                                                 m_last_reg;

    logic [sidta_pkg::NumDigits-1:0][3:0]                 conv_digits;
    logic [sidta_pkg::IndexWidth-1:0]                     lead;
    logic                                                 emit;

    assign conv_digits = conv.bcd;

    // Highest nonzero digit; zero points at the units digit.
    always_comb begin
        lead = '0;
        for (int i = 0; i < sidta_pkg::NumDigits; i++) begin
            if (conv_digits[i] != 4'd0) begin
                lead = sidta_pkg::IndexWidth'(i);
            end
        end
    end

    assign emit = active_reg && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (conv.valid) begin
                active_reg <= 1'b1;
            end else if (emit && !neg_reg && idx_reg == '0) begin
                active_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (conv.valid) begin
            digit_reg <= conv_digits;
            neg_reg   <= conv.neg;
            idx_reg   <= lead;
        end else if (emit) begin
            if (neg_reg) begin
                neg_reg        <= 1'b0;
                m_out_char_reg <= sidta_pkg::CharMinus;
                m_last_reg     <= 1'b0;
            end else begin
                m_out_char_reg <= sidta_pkg::CharZero + {4'd0, digit_reg[idx_reg]};
                m_last_reg     <= (idx_reg == '0);
                if (idx_reg != '0) begin
                    idx_reg <= idx_reg - 1'b1;
                end
            end
        end
    end

    assign busy       = active_reg;
    assign m_valid    = m_valid_reg;
    assign m_out_char = m_out_char_reg;
    assign m_last     = m_last_reg;

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        conv.valid |-> !active_reg)
        else $error("new number loaded while emitting");

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_out_char_reg == sidta_pkg::CharMinus ||
                         (m_out_char_reg >= sidta_pkg::CharZero &&
                          m_out_char_reg <= sidta_pkg::CharZero + 8'd9)))
        else $error("character outside sign and digit codes");

    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_out_char_reg == sidta_pkg::CharMinus) |-> !m_last_reg)
        else $error("sign flagged as final character");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> idx_reg < sidta_pkg::IndexWidth'(sidta_pkg::NumDigits))
        else $error("digit index out of range");

endmodule

[hw/rtl/signed_int_to_decimal_ascii.sv]
// Top level of the signed 32-bit integer to decimal ASCII converter.
`timescale 1ns / 1ps

// Takes one signed 32-bit value per transaction and sends its decimal text as
// one ASCII character per transaction on the m_ side, most significant first,
// with a leading '-' for negative values, no leading zeros, and m_last on the
// final character. The magnitude goes through a shift/add-3 BCD unit that runs
// one step per cycle, then the emitter sends up to 11 characters at one per
// cycle when the output is not stalled. s_ready is low while a value is being
// converted or emitted; the final character may still sit in the output
// register while the next value is accepted.
module signed_int_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_last
);

    logic                            start;
    logic                            neg;
    logic [sidta_pkg::DataWidth-1:0] mag;
    logic                            dabble_busy;
    logic                            emit_busy;
    sidta_pkg::sidta_conv_t          conv;

    // Unsigned negate keeps the most negative value as 2147483648.
    assign neg   = s_value[sidta_pkg::DataWidth-1];
    assign mag   = neg ? (sidta_pkg::DataWidth'(0) - $unsigned(s_value)) : $unsigned(s_value);
    assign s_ready = !dabble_busy && !emit_busy;
    assign start   = s_valid && s_ready;

    sidta_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .neg     (neg),
        .mag     (mag),
        .busy    (dabble_busy),
        .conv    (conv)
    );

    sidta_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .conv       (conv),
        .busy       (emit_busy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

[tb/sv/ascii_text_checker.sv]
// Checker that predicts the decimal ASCII text of each accepted value and compares it.
`timescale 1ns / 1ps

module ascii_text_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [7:0]         m_out_char,
    input  logic               m_last,
    output int                 fail_count,
    output int                 chars_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    text_char_t expected_chars[$];
    int         mismatch_total = 0;

    // Queue the characters of one value: sign first, then digits most significant first.
    function automatic void queue_decimal_text(input logic [31:0] raw);
        logic       neg;
        logic [31:0] mag;
        logic [3:0] digits [10];
        int         n;
        neg = raw[31];
        // Two's complement negate; the most negative value maps to 2147483648 unsigned.
        mag = neg ? (~raw + 32'd1) : raw;
        n = 0;
        do begin
            digits[n] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            n++;
        end while (mag != 32'd0 && n < 10);
        if (neg) begin
            expected_chars.push_back('{ch: sidta_pkg::CharMinus, last: 1'b0});
        end
        for (int i = n - 1; i >= 0; i--) begin
            expected_chars.push_back('{ch: sidta_pkg::CharZero + {4'd0, digits[i]},
                                       last: (i == 0)});
        end
    endfunction

    always @(posedge aclk) begin
        text_char_t want;
        if (!aresetn) begin
            expected_chars.delete();
        end else begin
            // Compare before predicting so a stray character never matches a fresh value.
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character transaction: out_char %0d last %0d",
                           m_out_char, m_last);
                    mismatch_total++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_out_char !== want.ch) begin
                        $error("out_char mismatch: expected %0d, actual %0d",
                               want.ch, m_out_char);
                        mismatch_total++;
                    end
                    if (m_last !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d", want.last, m_last);
                        mismatch_total++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                queue_decimal_text(s_value);
            end
        end
        fail_count    <= mismatch_total;
        chars_pending <= expected_chars.size();
    end

endmodule

[tb/sv/tb_signed_int_to_decimal_ascii.sv]
// Top of the testbench: stimulus, output backpressure, watchdog and verdict.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    localparam int ResetCycles   = 12;
    localparam int LongHold      = 400;
    localparam int WatchdogLimit = 5000;
    localparam int TailCycles    = 60;
    localparam int PhaseItems    = 25;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_out_char;
    logic               m_last;

    int fail_count;
    int chars_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int idle_cycles    = 0;

    signed_int_to_decimal_ascii dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

    ascii_text_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one value, idling first at the current rate; return at the accepting edge.
    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the input until every predicted character has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chars_pending != 0);
    endtask

    // Mix of full-range, short, bit-limited and power-of-ten boundary values.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        logic [31:0] pw;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(999);
            2: v = $urandom >> $urandom_range(31);
            default: begin
                pw = 32'd1;
                repeat ($urandom_range(9)) pw = pw * 32'd10;
                v = pw + $urandom_range(2) - 32'd1;
            end
        endcase
        if ($urandom_range(1) == 1) begin
            v = ~v + 32'd1;
        end
        return v;
    endfunction

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                m_ready <= 1'b0;
                repeat (LongHold) @(posedge aclk);
                holds_served++;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with work outstanding but no transaction on either side.
    initial begin
        while (idle_cycles < WatchdogLimit) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else if (aresetn && (s_valid || chars_pending != 0)) begin
                idle_cycles++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [31:0] directed [$];
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_value <= '0;
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero, single digits, width boundaries, and the most negative value.
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                     32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                     32'd999999999, 32'd1000000000, -32'sd999999999, -32'sd1000000000,
                     32'd12345, -32'sd54321, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h7FFF_FFFE, 32'd4294967286, 32'd1000};
        foreach (directed[i]) send_value(directed[i]);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            // Stall the output for a long stretch while values keep coming in.
            if (phase == 0) begin
                hold_requests <= hold_requests + 1;
            end
            for (int n = 0; n < PhaseItems; n++) send_value(pick_value());
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TailCycles) @(posedge aclk);
        if (fail_count == 0 && chars_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
